[rtl/elps_pkg.sv]
// Shared constants and types for the epsilon lexicase parent selection block.
package elps_pkg;
    localparam int IND_W   = 8;
    localparam int CASE_W  = 6;
    localparam int ERR_W   = 32;
    localparam int ADDR_W  = IND_W + CASE_W;
    localparam int NUM_IND = 1 << IND_W;
    localparam int NUM_CASE = 1 << CASE_W;
    localparam int CNT_W   = IND_W + 1;
    localparam int DIV_W   = 2 * ERR_W + IND_W;

    localparam logic [1:0] OP_LOAD_ERR   = 2'd0;
    localparam logic [1:0] OP_LOAD_ORDER = 2'd1;
    localparam logic [1:0] OP_CONDITION  = 2'd2;
    localparam logic [1:0] OP_SELECT     = 2'd3;

    localparam logic [1:0] MODE_RAW = 2'd0;
    localparam logic [1:0] MODE_REL = 2'd1;
    localparam logic [1:0] MODE_ABS = 2'd2;
    localparam logic [1:0] MODE_STD = 2'd3;

    localparam logic [2:0] REG_NUM_CASES = 3'd0;
    localparam logic [2:0] REG_META      = 3'd1;
    localparam logic [2:0] REG_MODE      = 3'd2;
    localparam logic [2:0] REG_EPSILON   = 3'd3;
    localparam logic [2:0] REG_MAX_ERR   = 3'd4;

    localparam logic [ERR_W-1:0] FAIL_VALUE = ERR_W'(32'h0001_0000);

    typedef struct packed {
        logic start;
        logic done;
    } t_unit_ctl;
endpackage

[rtl/elps_if.sv]
// Channel interfaces: input transactions and result transactions.
interface elps_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  op;
    logic [7:0]  individual;
    logic [5:0]  case_index;
    logic [5:0]  order_position;
    logic [31:0] error_value;
    logic [15:0] random_value;
    modport source (output valid, op, individual, case_index, order_position,
                    error_value, random_value, input ready);
    modport sink (input valid, op, individual, case_index, order_position,
                  error_value, random_value, output ready);
endinterface

interface elps_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] parent_index;
    logic [5:0] cases_used;
    logic [8:0] winner_count;
    logic       no_winner;
    modport source (output valid, parent_index, cases_used, winner_count, no_winner,
                    input ready);
    modport sink (input valid, parent_index, cases_used, winner_count, no_winner,
                  output ready);
endinterface

[rtl/elps_div.sv]
// Bit-serial restoring divider: wide dividend by a narrow divisor.
module elps_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [elps_pkg::DIV_W-1:0]  i_dividend,
    input  logic [elps_pkg::CNT_W-1:0]  i_divisor,
    output logic                        o_done,
    output logic [elps_pkg::DIV_W-1:0]  o_quotient
);
    import elps_pkg::*;

    localparam int STEP_W = $clog2(DIV_W + 1);

    logic [DIV_W-1:0]  r_q;
    logic [CNT_W-1:0]  r_rem, r_div;
    logic [STEP_W-1:0] r_cnt;
    logic              r_busy, r_done;
    logic [CNT_W:0]    w_sh;
    logic              w_ge;

    assign w_sh = {r_rem, r_q[DIV_W-1]};
    assign w_ge = w_sh >= {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= STEP_W'(DIV_W);
                r_q    <= i_dividend;
                r_div  <= i_divisor;
                r_rem  <= '0;
            end else if (r_busy) begin
                r_q   <= {r_q[DIV_W-2:0], w_ge};
                r_rem <= w_ge ? CNT_W'(w_sh - {1'b0, r_div}) : CNT_W'(w_sh);
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == STEP_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_q;
endmodule

[rtl/elps_sqrt.sv]
// Digit-by-digit integer square root, two radicand bits per cycle.
module elps_sqrt (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [2*elps_pkg::ERR_W-1:0]  i_value,
    output logic                          o_done,
    output logic [elps_pkg::ERR_W-1:0]    o_root
);
    import elps_pkg::*;

    localparam int STEP_W = $clog2(ERR_W + 1);

    logic [2*ERR_W-1:0] r_v;
    logic [ERR_W+1:0]   r_rem;
    logic [ERR_W-1:0]   r_root;
    logic [STEP_W-1:0]  r_cnt;
    logic               r_busy, r_done;
    logic [ERR_W+1:0]   w_sh, w_trial;
    logic               w_ge;

    assign w_sh    = {r_rem[ERR_W-1:0], r_v[2*ERR_W-1 -: 2]};
    assign w_trial = {r_root, 2'b01};
    assign w_ge    = w_sh >= w_trial;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= STEP_W'(ERR_W);
                r_v    <= i_value;
                r_rem  <= '0;
                r_root <= '0;
            end else if (r_busy) begin
                r_v    <= {r_v[2*ERR_W-3:0], 2'b00};
                r_rem  <= w_ge ? w_sh - w_trial : w_sh;
                r_root <= {r_root[ERR_W-2:0], w_ge};
                r_cnt  <= r_cnt - 1'b1;
                if (r_cnt == STEP_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;
endmodule

[rtl/epsilon_lexicase_parent_selection.sv]
// Top level: epsilon lexicase parent selection sequencer, stores and datapath.
//
// Load-error and load-order transactions complete in the idle state. A
// condition transaction walks every conditioned column through the
// single-port error memory. Each column gets a minimum scan over all
// individuals and a rewrite scan with one write per member. Std mode adds
// a sum scan, a squared-deviation scan, up to two divides and a square root
// per column. A select transaction reads the order entry and scans all 256
// individuals per case position reached, then locates the ranked tie
// winner. The input is not ready while an operation runs; a finished result
// waits in the output register while the next transaction is accepted.
module epsilon_lexicase_parent_selection (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [2:0]        i_cfg_idx,
    input  logic [31:0]       i_cfg_data,
    elps_in_if.sink           i_in,
    elps_out_if.source        o_res
);
    import elps_pkg::*;

    localparam logic [4:0] S_IDLE    = 5'd0;
    localparam logic [4:0] S_CMIN_RD = 5'd1;
    localparam logic [4:0] S_CMIN_EV = 5'd2;
    localparam logic [4:0] S_CLIM    = 5'd3;
    localparam logic [4:0] S_CLIM2   = 5'd4;
    localparam logic [4:0] S_SUM_RD  = 5'd5;
    localparam logic [4:0] S_SUM_EV  = 5'd6;
    localparam logic [4:0] S_MEAN_W  = 5'd7;
    localparam logic [4:0] S_SQ_RD   = 5'd8;
    localparam logic [4:0] S_SQ_D    = 5'd9;
    localparam logic [4:0] S_SQ_M    = 5'd10;
    localparam logic [4:0] S_SQ_ACC  = 5'd11;
    localparam logic [4:0] S_VAR_W   = 5'd12;
    localparam logic [4:0] S_SQRT_W  = 5'd13;
    localparam logic [4:0] S_LIM3    = 5'd14;
    localparam logic [4:0] S_PASS_RD = 5'd15;
    localparam logic [4:0] S_PASS_EV = 5'd16;
    localparam logic [4:0] S_PASS_WR = 5'd17;
    localparam logic [4:0] S_SEL_SEQ = 5'd18;
    localparam logic [4:0] S_SEL_COL = 5'd19;
    localparam logic [4:0] S_SEL_RD  = 5'd20;
    localparam logic [4:0] S_SEL_EV  = 5'd21;
    localparam logic [4:0] S_SEL_DEC = 5'd22;
    localparam logic [4:0] S_RANK    = 5'd23;
    localparam logic [4:0] S_RANK2   = 5'd24;
    localparam logic [4:0] S_PICK    = 5'd25;
    localparam logic [4:0] S_OUT     = 5'd26;
    localparam logic [4:0] S_SQ_DIV  = 5'd27;

    // configuration
    logic [6:0]       r_num_cases;
    logic [1:0]       r_meta, r_mode;
    logic [ERR_W-1:0] r_eps, r_max_err;

    // stores
    logic [ERR_W-1:0]  r_err_mem [NUM_CASE*NUM_IND];
    logic [CASE_W-1:0] r_seq_mem [NUM_CASE];
    logic [ERR_W-1:0]  r_rd;
    logic [CASE_W-1:0] r_seq_rd;
    logic [NUM_IND-1:0] r_member, r_pool, r_win;

    // sequencer and datapath
    logic [4:0]          r_state;
    logic [IND_W-1:0]    r_i;
    logic [CASE_W-1:0]   r_c, r_col, r_h;
    logic [6:0]          r_m;
    logic [ERR_W-1:0]    r_mn, r_mean, r_d, r_spread, r_wd;
    logic [2*ERR_W-1:0]  r_prod, r_lim;
    logic [CNT_W-1:0]    r_n, r_cnt, r_rank;
    logic [ERR_W+IND_W-1:0] r_sum;
    logic [DIV_W-1:0]    r_sq;
    logic [15:0]         r_rnd;
    logic [IND_W-1:0]    r_pick;

    // result register
    logic              r_ov;
    logic [IND_W-1:0]  r_o_par;
    logic [CASE_W-1:0] r_o_used;
    logic [CNT_W-1:0]  r_o_cnt;
    logic              r_o_nw;

    logic [ADDR_W-1:0]  w_addr;
    logic               w_we;
    logic [ERR_W-1:0]   w_wdata;
    logic               w_acc, w_last, w_sel_st;
    logic [6:0]         w_eff, w_m;
    logic [ERR_W-1:0]   w_mul_a, w_mul_b;
    logic [2*ERR_W-1:0] w_mul;
    t_unit_ctl          w_div_ctl, w_sqrt_ctl;
    logic [DIV_W-1:0]   w_div_a, w_div_q;
    logic [CNT_W-1:0]   w_div_b;
    logic [ERR_W-1:0]   w_root;

    assign w_acc  = i_in.valid && i_in.ready;
    assign w_last = (r_i == IND_W'(NUM_IND - 1));
    assign i_in.ready = (r_state == S_IDLE);

    // clamp the case count, then drop the trailing meta columns
    always_comb begin
        if (r_num_cases == 7'd0) begin
            w_eff = 7'd1;
        end else if (r_num_cases > 7'(NUM_CASE)) begin
            w_eff = 7'(NUM_CASE);
        end else begin
            w_eff = r_num_cases;
        end
        w_m = (w_eff > {5'd0, r_meta}) ? w_eff - {5'd0, r_meta} : 7'd0;
    end

    // the one shared multiplier
    always_comb begin
        case (r_state)
            S_CLIM: begin
                w_mul_a = r_mn;
                w_mul_b = r_eps;
            end
            S_RANK: begin
                w_mul_a = ERR_W'(r_rnd);
                w_mul_b = ERR_W'(r_cnt);
            end
            default: begin
                w_mul_a = r_d;
                w_mul_b = r_d;
            end
        endcase
        w_mul = w_mul_a * w_mul_b;
    end

    // error memory port
    assign w_sel_st = (r_state == S_SEL_RD);
    always_comb begin
        if (r_state == S_IDLE) begin
            w_addr = {i_in.individual, i_in.case_index};
        end else if (w_sel_st) begin
            w_addr = {r_i, r_col};
        end else begin
            w_addr = {r_i, r_c};
        end
        w_we    = (r_state == S_PASS_WR) || (w_acc && i_in.op == OP_LOAD_ERR);
        w_wdata = (r_state == S_PASS_WR) ? r_wd : i_in.error_value;
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_err_mem[w_addr] <= w_wdata;
        end
        r_rd <= r_err_mem[w_addr];
        if (w_acc && i_in.op == OP_LOAD_ORDER) begin
            r_seq_mem[i_in.order_position] <= i_in.case_index;
        end
        r_seq_rd <= r_seq_mem[r_h];
    end

    assign w_div_ctl.start  = (r_state == S_SUM_EV && w_last && r_n != '0
                               && !(r_n == CNT_W'(1) && !r_member[r_i]))
                              || (r_state == S_SQ_DIV);
    assign w_div_a = (r_state == S_SQ_DIV) ? r_sq
                   : DIV_W'(r_sum + (r_member[r_i] ? (ERR_W+IND_W)'(r_rd) : '0));
    assign w_div_b = (r_state == S_SQ_DIV) ? r_n - 1'b1
                   : r_n + CNT_W'(r_member[r_i]);
    assign w_sqrt_ctl.start = (r_state == S_VAR_W) && w_div_ctl.done
                              && (w_div_q[DIV_W-1:2*ERR_W] == '0);

    elps_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_ctl.start),
        .i_dividend (w_div_a),
        .i_divisor  (w_div_b),
        .o_done     (w_div_ctl.done),
        .o_quotient (w_div_q)
    );

    elps_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_sqrt_ctl.start),
        .i_value (w_div_q[2*ERR_W-1:0]),
        .o_done  (w_sqrt_ctl.done),
        .o_root  (w_root)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_member    <= '0;
            r_pool      <= '0;
            r_win       <= '0;
            r_ov        <= 1'b0;
            r_num_cases <= 7'd64;
            r_meta      <= 2'd0;
            r_mode      <= MODE_RAW;
            r_eps       <= '0;
            r_max_err   <= '1;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_NUM_CASES: r_num_cases <= i_cfg_data[6:0];
                    REG_META:      r_meta      <= i_cfg_data[1:0];
                    REG_MODE:      r_mode      <= i_cfg_data[1:0];
                    REG_EPSILON:   r_eps       <= i_cfg_data;
                    REG_MAX_ERR:   r_max_err   <= i_cfg_data;
                    default: ;
                endcase
            end
            // the result register is reloaded in S_OUT, so drop it only elsewhere
            if (o_res.valid && o_res.ready && r_state != S_OUT) begin
                r_ov <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    r_i  <= '0;
                    r_c  <= '0;
                    r_h  <= '0;
                    r_mn <= r_max_err;
                    r_m  <= w_m;
                    if (w_acc) begin
                        case (i_in.op)
                            OP_LOAD_ERR: r_member[i_in.individual] <= 1'b1;
                            OP_CONDITION: begin
                                if (r_mode != MODE_RAW && w_m != 7'd0) begin
                                    r_state <= S_CMIN_RD;
                                end
                            end
                            OP_SELECT: begin
                                r_pool  <= r_member;
                                r_rnd   <= i_in.random_value;
                                r_state <= S_SEL_SEQ;
                            end
                            default: ;
                        endcase
                    end
                end

                // column minimum over the members
                S_CMIN_RD: r_state <= S_CMIN_EV;
                S_CMIN_EV: begin
                    if (r_member[r_i] && r_rd < r_mn) begin
                        r_mn <= r_rd;
                    end
                    r_i <= r_i + 1'b1;
                    if (!w_last) begin
                        r_state <= S_CMIN_RD;
                    end else begin
                        case (r_mode)
                            MODE_REL: r_state <= S_CLIM;
                            MODE_ABS: begin
                                r_lim   <= (2*ERR_W)'(r_eps);
                                r_state <= S_PASS_RD;
                            end
                            default: begin
                                r_n     <= '0;
                                r_sum   <= '0;
                                r_state <= S_SUM_RD;
                            end
                        endcase
                    end
                end
                S_CLIM: begin
                    r_prod  <= w_mul;
                    r_state <= S_CLIM2;
                end
                S_CLIM2: begin
                    r_lim   <= (2*ERR_W)'(r_mn) + (r_prod >> 16);
                    r_state <= S_PASS_RD;
                end

                // std mode: mean, squared deviations, variance, root
                S_SUM_RD: r_state <= S_SUM_EV;
                S_SUM_EV: begin
                    if (r_member[r_i]) begin
                        r_n   <= r_n + 1'b1;
                        r_sum <= r_sum + (ERR_W+IND_W)'(r_rd);
                    end
                    r_i <= r_i + 1'b1;
                    if (!w_last) begin
                        r_state <= S_SUM_RD;
                    end else if (w_div_ctl.start) begin
                        r_state <= S_MEAN_W;
                    end else begin
                        r_spread <= '0;
                        r_state  <= S_LIM3;
                    end
                end
                S_MEAN_W: begin
                    if (w_div_ctl.done) begin
                        if (r_n < CNT_W'(2)) begin
                            r_spread <= '0;
                            r_state  <= S_LIM3;
                        end else begin
                            r_mean  <= w_div_q[ERR_W-1:0];
                            r_sq    <= '0;
                            r_state <= S_SQ_RD;
                        end
                    end
                end
                S_SQ_RD: r_state <= S_SQ_D;
                S_SQ_D: begin
                    if (!r_member[r_i]) begin
                        r_d <= '0;
                    end else if (r_rd >= r_mean) begin
                        r_d <= r_rd - r_mean;
                    end else begin
                        r_d <= r_mean - r_rd;
                    end
                    r_state <= S_SQ_M;
                end
                S_SQ_M: begin
                    r_prod  <= w_mul;
                    r_state <= S_SQ_ACC;
                end
                S_SQ_ACC: begin
                    r_sq <= r_sq + DIV_W'(r_prod);
                    r_i  <= r_i + 1'b1;
                    r_state <= w_last ? S_SQ_DIV : S_SQ_RD;
                end
                S_SQ_DIV: r_state <= S_VAR_W;
                S_VAR_W: begin
                    if (w_div_ctl.done) begin
                        if (w_div_q[DIV_W-1:2*ERR_W] != '0) begin
                            r_spread <= '1;
                            r_state  <= S_LIM3;
                        end else begin
                            r_state <= S_SQRT_W;
                        end
                    end
                end
                S_SQRT_W: begin
                    if (w_sqrt_ctl.done) begin
                        r_spread <= w_root;
                        r_state  <= S_LIM3;
                    end
                end
                S_LIM3: begin
                    r_lim   <= (2*ERR_W)'(r_mn) + (2*ERR_W)'(r_spread);
                    r_state <= S_PASS_RD;
                end

                // rewrite member errors as pass or fail
                S_PASS_RD: r_state <= S_PASS_EV;
                S_PASS_EV: begin
                    r_wd <= ((2*ERR_W)'(r_rd) <= r_lim) ? '0 : FAIL_VALUE;
                    if (r_member[r_i]) begin
                        r_state <= S_PASS_WR;
                    end else begin
                        r_i <= r_i + 1'b1;
                        if (w_last) begin
                            r_c  <= r_c + 1'b1;
                            r_mn <= r_max_err;
                            r_state <= (7'(r_c) + 7'd1 == r_m) ? S_IDLE : S_CMIN_RD;
                        end else begin
                            r_state <= S_PASS_RD;
                        end
                    end
                end
                S_PASS_WR: begin
                    r_i <= r_i + 1'b1;
                    if (w_last) begin
                        r_c  <= r_c + 1'b1;
                        r_mn <= r_max_err;
                        r_state <= (7'(r_c) + 7'd1 == r_m) ? S_IDLE : S_CMIN_RD;
                    end else begin
                        r_state <= S_PASS_RD;
                    end
                end

                // select: filter the pool one case at a time
                S_SEL_SEQ: r_state <= S_SEL_COL;
                S_SEL_COL: begin
                    r_col   <= r_seq_rd;
                    r_i     <= '0;
                    r_mn    <= r_max_err;
                    r_cnt   <= '0;
                    r_win   <= '0;
                    r_state <= S_SEL_RD;
                end
                S_SEL_RD: r_state <= S_SEL_EV;
                S_SEL_EV: begin
                    if (r_pool[r_i]) begin
                        if (r_rd < r_mn) begin
                            r_mn  <= r_rd;
                            r_win <= NUM_IND'(1) << r_i;
                            r_cnt <= CNT_W'(1);
                        end else if (r_rd == r_mn) begin
                            r_win[r_i] <= 1'b1;
                            r_cnt      <= r_cnt + 1'b1;
                        end
                    end
                    r_i <= r_i + 1'b1;
                    r_state <= w_last ? S_SEL_DEC : S_SEL_RD;
                end
                S_SEL_DEC: begin
                    if (r_cnt > CNT_W'(1) && 7'(r_h) + 7'd1 < w_eff) begin
                        r_pool  <= r_win;
                        r_h     <= r_h + 1'b1;
                        r_state <= S_SEL_SEQ;
                    end else begin
                        r_state <= S_RANK;
                    end
                end
                S_RANK: begin
                    r_prod  <= w_mul;
                    r_state <= S_RANK2;
                end
                S_RANK2: begin
                    r_rank  <= r_prod[16 +: CNT_W];
                    r_pick  <= '0;
                    r_i     <= '0;
                    r_state <= S_PICK;
                end
                S_PICK: begin
                    r_i <= r_i + 1'b1;
                    if (r_win[r_i]) begin
                        r_rank <= r_rank - 1'b1;
                        if (r_rank == '0) begin
                            r_pick <= r_i;
                        end
                    end
                    if ((r_win[r_i] && r_rank == '0) || w_last) begin
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    // hold until the result register is free
                    if (!r_ov || o_res.ready) begin
                        r_ov     <= 1'b1;
                        r_o_par  <= (r_cnt != '0) ? r_pick : '0;
                        r_o_used <= r_h;
                        r_o_cnt  <= r_cnt;
                        r_o_nw   <= (r_cnt == '0);
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_res.valid        = r_ov;
    assign o_res.parent_index = r_o_par;
    assign o_res.cases_used   = r_o_used;
    assign o_res.winner_count = r_o_cnt;
    assign o_res.no_winner    = r_o_nw;

`ifndef SYNTHESIS
    a_nw_matches_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ov |-> (r_o_nw == (r_o_cnt == '0)))
        else $error("no_winner disagrees with winner_count");
    a_select_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && i_in.op == OP_SELECT) |=> !i_in.ready)
        else $error("ready after select transaction");
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_SEL_DEC |-> r_cnt <= CNT_W'(NUM_IND))
        else $error("winner count overflow");
`endif
endmodule

[tb/sv/tb_epsilon_lexicase_parent_selection.sv]
// Self-checking testbench for epsilon_lexicase_parent_selection.
module tb_epsilon_lexicase_parent_selection;
    timeunit 1ns;
    timeprecision 1ps;
    import elps_pkg::*;

    localparam int CYCLE_LIMIT = 6_000_000;

    // One input transaction and one selection result.
    typedef struct packed {
        logic [1:0]  op;
        logic [7:0]  ind;
        logic [5:0]  col;
        logic [5:0]  pos;
        logic [31:0] err;
        logic [15:0] rnd;
    } t_txn;

    typedef struct packed {
        logic [7:0] parent;
        logic [5:0] used;
        logic [8:0] winners;
        logic       none;
    } t_pick;

    // Directed stimulus row: either a register write or a transaction,
    // optionally with a hand-written expected pick.
    typedef struct {
        bit          is_cfg;
        logic [2:0]  reg_idx;
        logic [31:0] reg_val;
        t_txn        txn;
        bit          typed;
        t_pick       want;
    } t_row;

    typedef struct {
        int          ncases;
        int          meta;
        logic [1:0]  mode;
        logic [31:0] eps;
        logic [31:0] maxe;
        int          items;
    } t_phase;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic i_cfg_we;
    logic [2:0] i_cfg_idx;
    logic [31:0] i_cfg_data;

    elps_in_if  in_ch ();
    elps_out_if res_ch ();

    epsilon_lexicase_parent_selection i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (in_ch),
        .o_res      (res_ch)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // ---------------------------------------------------------------
    // Predictor state: error matrix, member map, case order, registers.
    // The *_seen maps record which entries were written, so that the
    // stimulus never makes the block read an undefined entry.
    // ---------------------------------------------------------------
    logic [31:0] err_mem   [NUM_IND][NUM_CASE];
    bit          err_seen  [NUM_IND][NUM_CASE];
    bit          member    [NUM_IND];
    int          member_list [$];
    logic [5:0]  order_mem [NUM_CASE];
    bit          order_seen[NUM_CASE];

    logic [6:0]  ncases_reg = 7'd64;
    logic [1:0]  meta_reg   = 2'd0;
    logic [1:0]  mode_reg   = MODE_RAW;
    logic [31:0] eps_reg    = 32'd0;
    logic [31:0] maxerr_reg = 32'hFFFF_FFFF;

    t_pick pending_picks [$];
    int    fails = 0;
    int    sent = 0;
    int    settle_cycles = 8;
    int    tx_idle_pct = 26;
    int    rx_idle_pct = 55;
    bit    hold_req = 1'b0;
    bit    hold_done = 1'b0;
    int    hold_left = 0;
    longint cycles = 0;

    function automatic int eff_cases();
        int n;
        n = ncases_reg;
        if (n < 1) n = 1;
        if (n > NUM_CASE) n = NUM_CASE;
        return n;
    endfunction

    function automatic longint unsigned isqrt64(longint unsigned v);
        longint unsigned res, b;
        res = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= res + b) begin
                v -= res + b;
                res = (res >> 1) + b;
            end else begin
                res >>= 1;
            end
            b >>= 2;
        end
        return res;
    endfunction

    // Sample standard deviation of one column over the members, 16.16.
    function automatic logic [31:0] column_spread(int c);
        longint unsigned cnt, sum, mean, e, d, root;
        logic [127:0] sq, q;
        cnt = 0;
        sum = 0;
        sq = '0;
        foreach (member[i]) if (member[i]) begin
            cnt++;
            sum += err_mem[i][c];
        end
        if (cnt < 2) return 32'd0;
        mean = sum / cnt;
        foreach (member[i]) if (member[i]) begin
            e = err_mem[i][c];
            d = (e >= mean) ? e - mean : mean - e;
            d &= 64'hFFFF_FFFF;
            sq += 128'(d * d);
        end
        q = sq / 128'(cnt - 1);
        if (q[127:64] != 0) return 32'hFFFF_FFFF;
        root = isqrt64(q[63:0]);
        return root[31:0];
    endfunction

    // In the conditioning modes, turn the members' non-meta columns into pass/fail values.
    function automatic void apply_condition();
        int n, m;
        longint unsigned mn, lim;
        n = eff_cases();
        m = (n > meta_reg) ? n - meta_reg : 0;
        if (mode_reg == MODE_RAW) return;
        for (int c = 0; c < m; c++) begin
            mn = maxerr_reg;
            foreach (member[i])
                if (member[i] && err_mem[i][c] < mn) mn = err_mem[i][c];
            case (mode_reg)
                MODE_REL: lim = mn + ((mn * longint'(eps_reg)) >> 16);
                MODE_ABS: lim = eps_reg;
                default:  lim = mn + column_spread(c);
            endcase
            foreach (member[i])
                if (member[i])
                    err_mem[i][c] = (err_mem[i][c] <= lim) ? 32'd0 : FAIL_VALUE;
        end
    endfunction

    function automatic logic [31:0] rand_err();
        case ($urandom_range(0, 5))
            0: return 32'd0;
            1: return 32'h0001_0000;
            2: return 32'h0001_8000;
            3: return $urandom_range(0, 32'h0004_0000);
            4: return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    function automatic t_txn noise_txn(logic [1:0] op);
        t_txn t;
        t.op = op;
        t.ind = 8'($urandom);
        t.col = 6'($urandom);
        t.pos = 6'($urandom);
        t.err = $urandom;
        t.rnd = 16'($urandom);
        return t;
    endfunction

    // Walk the case order, narrowing the pool to the elites of each case.
    // If the walk would touch an unwritten entry, hand back the load that
    // fills it instead.
    task automatic predict_pick(input logic [15:0] rnd, output t_pick r,
                                output bit safe, output t_txn fix);
        bit pool [NUM_IND];
        bit win  [NUM_IND];
        int n, h, col, count, pick;
        bit go;
        longint unsigned mn, rank;
        n = eff_cases();
        pool = member;
        h = 0;
        go = 1'b1;
        safe = 1'b1;
        count = 0;
        fix = noise_txn(OP_LOAD_ERR);
        while (go) begin
            if (!order_seen[h]) begin
                safe = 1'b0;
                fix.op = OP_LOAD_ORDER;
                fix.pos = 6'(h);
                fix.col = 6'($urandom_range(0, n - 1));
                return;
            end
            col = order_mem[h];
            mn = maxerr_reg;
            count = 0;
            foreach (win[i]) win[i] = 1'b0;
            foreach (pool[i]) if (pool[i]) begin
                if (!err_seen[i][col]) begin
                    safe = 1'b0;
                    fix.ind = 8'(i);
                    fix.col = 6'(col);
                    fix.err = rand_err();
                    return;
                end
                if (err_mem[i][col] < mn) begin
                    mn = err_mem[i][col];
                    foreach (win[j]) win[j] = 1'b0;
                    win[i] = 1'b1;
                    count = 1;
                end else if (err_mem[i][col] == mn) begin
                    win[i] = 1'b1;
                    count++;
                end
            end
            if (count > 1 && h + 1 < n) begin
                pool = win;
                h++;
            end else begin
                go = 1'b0;
            end
        end
        rank = (longint'(rnd) * count) >> 16;
        pick = 0;
        foreach (win[i]) if (win[i]) begin
            if (rank == 0) begin
                pick = i;
                break;
            end
            rank--;
        end
        r.parent  = (count != 0) ? pick[7:0] : 8'd0;
        r.used    = h[5:0];
        r.winners = count[8:0];
        r.none    = (count == 0);
    endtask

    // Conditioning reads every member across the non-meta columns.
    task automatic condition_ready(output bit safe, output t_txn fix);
        int m;
        m = (eff_cases() > meta_reg) ? eff_cases() - meta_reg : 0;
        safe = 1'b1;
        fix = noise_txn(OP_LOAD_ERR);
        if (mode_reg == MODE_RAW) return;
        foreach (member[i]) if (member[i]) begin
            for (int c = 0; c < m; c++) begin
                if (!err_seen[i][c]) begin
                    safe = 1'b0;
                    fix.ind = 8'(i);
                    fix.col = 6'(c);
                    fix.err = rand_err();
                    return;
                end
            end
        end
    endtask

    // Update the predictor with one accepted transaction.
    task automatic absorb(input t_txn t, input bit typed, input t_pick want);
        t_pick p;
        bit ok;
        t_txn unused;
        settle_cycles = 8;
        case (t.op)
            OP_LOAD_ERR: begin
                err_mem[t.ind][t.col] = t.err;
                err_seen[t.ind][t.col] = 1'b1;
                if (!member[t.ind]) member_list.insert(member_list.size(), int'(t.ind));
                member[t.ind] = 1'b1;
            end
            OP_LOAD_ORDER: begin
                order_mem[t.pos] = t.col;
                order_seen[t.pos] = 1'b1;
            end
            OP_CONDITION: begin
                apply_condition();
                settle_cycles = ((mode_reg == MODE_STD) ? 3200 : 1300) * eff_cases() + 200;
            end
            default: begin
                predict_pick(t.rnd, p, ok, unused);
                pending_picks.insert(pending_picks.size(), typed ? want : p);
            end
        endcase
    endtask

    // Offer one transaction and hold it until the handshake completes.
    task automatic drive(input t_txn t, input bit typed, input t_pick want);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid          <= 1'b1;
        in_ch.op             <= t.op;
        in_ch.individual     <= t.ind;
        in_ch.case_index     <= t.col;
        in_ch.order_position <= t.pos;
        in_ch.error_value    <= t.err;
        in_ch.random_value   <= t.rnd;
        do @(posedge i_clk); while (!in_ch.ready);
        absorb(t, typed, want);
        sent++;
        // Idling schedule: receiver-heavy, then sender-heavy, then none.
        if (sent == 60) begin
            tx_idle_pct = 55;
            rx_idle_pct = 26;
        end
        if (sent == 110) begin
            tx_idle_pct = 0;
            rx_idle_pct = 0;
        end
        if (sent == 80) hold_req = 1'b1;
    endtask

    // Send a transaction, first filling any entry it would read unwritten.
    task automatic send(input t_txn t, input bit typed, input t_pick want);
        bit ok;
        t_txn fix;
        t_pick p;
        forever begin
            ok = 1'b1;
            if (t.op == OP_SELECT) predict_pick(t.rnd, p, ok, fix);
            else if (t.op == OP_CONDITION) condition_ready(ok, fix);
            if (ok) break;
            drive(fix, 1'b0, '0);
        end
        drive(t, typed, want);
    endtask

    // Drop valid and wait for every expected pick plus the tail of any
    // conditioning pass still running.
    task automatic quiesce();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending_picks.size() != 0) @(posedge i_clk);
        repeat (settle_cycles) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            REG_NUM_CASES: ncases_reg = val[6:0];
            REG_META:      meta_reg   = val[1:0];
            REG_MODE:      mode_reg   = val[1:0];
            REG_EPSILON:   eps_reg    = val;
            REG_MAX_ERR:   maxerr_reg = val;
            default: ;
        endcase
    endtask

    function automatic t_txn random_txn();
        t_txn t;
        int r;
        r = $urandom_range(0, 99);
        t = noise_txn(r < 35 ? OP_LOAD_ERR : r < 50 ? OP_LOAD_ORDER :
                      r < 58 ? OP_CONDITION : OP_SELECT);
        // Keep the population small so ties and deep walks are common.
        if (member_list.size() != 0 &&
            (member_list.size() >= 10 || $urandom_range(0, 99) >= 20))
            t.ind = 8'(member_list[$urandom_range(0, member_list.size() - 1)]);
        if ($urandom_range(0, 9) != 0) t.col = 6'($urandom_range(0, eff_cases() - 1));
        if ($urandom_range(0, 3) != 0) t.pos = 6'($urandom_range(0, eff_cases() - 1));
        t.err = rand_err();
        case ($urandom_range(0, 3))
            0: t.rnd = 16'h0000;
            1: t.rnd = 16'hFFFF;
            default: ;
        endcase
        return t;
    endfunction

    // ---------------------------------------------------------------
    // Result side: compare each accepted pick with the oldest expectation,
    // and toggle ready per the idling schedule. One long hold-off lets
    // the output register fill so that the input stalls.
    // ---------------------------------------------------------------
    always @(posedge i_clk) begin
        t_pick want;
        if (!i_rst_n) begin
            res_ch.ready <= 1'b0;
        end else begin
            if (res_ch.valid && res_ch.ready) begin
                if (pending_picks.size() == 0) begin
                    $error("unexpected result transaction");
                    fails++;
                end else begin
                    want = pending_picks.pop_front();
                    if (res_ch.parent_index !== want.parent) begin
                        $error("parent_index expected %0d got %0d", want.parent,
                               res_ch.parent_index);
                        fails++;
                    end
                    if (res_ch.cases_used !== want.used) begin
                        $error("cases_used expected %0d got %0d", want.used,
                               res_ch.cases_used);
                        fails++;
                    end
                    if (res_ch.winner_count !== want.winners) begin
                        $error("winner_count expected %0d got %0d", want.winners,
                               res_ch.winner_count);
                        fails++;
                    end
                    if (res_ch.no_winner !== want.none) begin
                        $error("no_winner expected %0d got %0d", want.none,
                               res_ch.no_winner);
                        fails++;
                    end
                end
            end
            if (hold_left > 0) begin
                hold_left--;
                res_ch.ready <= 1'b0;
            end else if (hold_req && !hold_done) begin
                hold_done = 1'b1;
                hold_left = 6000;
                res_ch.ready <= 1'b0;
            end else begin
                res_ch.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
            end
        end
    end

    // Watchdog.
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("epsilon_lexicase_parent_selection verification failed");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // Stimulus.
    // ---------------------------------------------------------------
    function automatic t_row row_cfg(logic [2:0] idx, logic [31:0] val);
        t_row r;
        r = '{default: '0};
        r.is_cfg = 1'b1;
        r.reg_idx = idx;
        r.reg_val = val;
        return r;
    endfunction

    function automatic t_row row_txn(logic [1:0] op, logic [7:0] ind, logic [5:0] col,
                                     logic [5:0] pos, logic [31:0] err,
                                     logic [15:0] rnd);
        t_row r;
        r = '{default: '0};
        r.txn = '{op: op, ind: ind, col: col, pos: pos, err: err, rnd: rnd};
        return r;
    endfunction

    function automatic t_row row_empty(logic [15:0] rnd);
        t_row r;
        r = row_txn(OP_SELECT, 8'hFF, 6'h3F, 6'h3F, 32'hFFFF_FFFF, rnd);
        r.typed = 1'b1;
        r.want = '{parent: 8'd0, used: 6'd0, winners: 9'd0, none: 1'b1};
        return r;
    endfunction

    t_row   directed [$];
    t_phase phases [$];

    // Append one row to the directed table.
    function automatic void add_row(t_row r);
        directed.insert(directed.size(), r);
    endfunction

    // Append one random phase.
    function automatic void add_phase(t_phase ph);
        phases.insert(phases.size(), ph);
    endfunction

    initial begin
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = '0;
        i_cfg_data = '0;
        in_ch.valid = 1'b0;
        in_ch.op = OP_LOAD_ERR;
        in_ch.individual = '0;
        in_ch.case_index = '0;
        in_ch.order_position = '0;
        in_ch.error_value = '0;
        in_ch.random_value = '0;
        res_ch.ready = 1'b0;
        foreach (member[i]) member[i] = 1'b0;

        // Empty pool first, then a two-individual pool at the index extremes,
        // each mode in turn, max_error below every error, meta covering all.
        add_row(row_empty(16'hFFFF));
        add_row(row_cfg(REG_NUM_CASES, 32'd2));
        add_row(row_txn(OP_LOAD_ORDER, 8'd0, 6'd1, 6'd0, 32'd0, 16'd0));
        add_row(row_txn(OP_LOAD_ORDER, 8'd0, 6'd0, 6'd1, 32'd0, 16'd0));
        add_row(row_txn(OP_LOAD_ORDER, 8'd0, 6'h3F, 6'h3F, 32'd0, 16'd0));
        add_row(row_txn(OP_LOAD_ERR, 8'd0, 6'd0, 6'd0, 32'd0, 16'd0));
        add_row(row_txn(OP_LOAD_ERR, 8'd255, 6'd0, 6'd0, 32'd0, 16'd0));
        add_row(row_txn(OP_LOAD_ERR, 8'd0, 6'd1, 6'd0, 32'hFFFF_FFFF, 16'd0));
        add_row(row_txn(OP_LOAD_ERR, 8'd255, 6'd1, 6'd0, 32'hFFFF_FFFF, 16'd0));
        add_row(row_txn(OP_LOAD_ERR, 8'd0, 6'h3F, 6'd0, 32'h1234_5678, 16'd0));
        add_row(row_txn(OP_SELECT, 8'd0, 6'd0, 6'd0, 32'd0, 16'h0000));
        add_row(row_txn(OP_SELECT, 8'd0, 6'd0, 6'd0, 32'd0, 16'hFFFF));
        add_row(row_cfg(REG_MAX_ERR, 32'd0));
        add_row(row_empty(16'h8000));
        add_row(row_cfg(REG_MAX_ERR, 32'hFFFF_FFFF));
        add_row(row_txn(OP_LOAD_ERR, 8'd255, 6'd1, 6'd0, 32'h0001_8000, 16'd0));
        add_row(row_cfg(REG_MODE, MODE_REL));
        add_row(row_cfg(REG_EPSILON, 32'h0000_8000));
        add_row(row_txn(OP_CONDITION, 8'd0, 6'd0, 6'd0, 32'd0, 16'd0));
        add_row(row_txn(OP_SELECT, 8'd0, 6'd0, 6'd0, 32'd0, 16'h7FFF));
        add_row(row_cfg(REG_MODE, MODE_ABS));
        add_row(row_cfg(REG_EPSILON, 32'hFFFF_FFFF));
        add_row(row_txn(OP_CONDITION, 8'd0, 6'd0, 6'd0, 32'd0, 16'd0));
        add_row(row_txn(OP_SELECT, 8'd0, 6'd0, 6'd0, 32'd0, 16'hFFFF));
        add_row(row_txn(OP_LOAD_ERR, 8'd0, 6'd0, 6'd0, 32'h0003_0000, 16'd0));
        add_row(row_cfg(REG_MODE, MODE_STD));
        add_row(row_cfg(REG_META, 32'd1));
        add_row(row_txn(OP_CONDITION, 8'd0, 6'd0, 6'd0, 32'd0, 16'd0));
        add_row(row_txn(OP_SELECT, 8'd0, 6'd0, 6'd0, 32'd0, 16'h1234));
        add_row(row_cfg(REG_META, 32'd3));
        add_row(row_txn(OP_CONDITION, 8'd0, 6'd0, 6'd0, 32'd0, 16'd0));
        add_row(row_cfg(REG_MODE, MODE_RAW));
        add_row(row_txn(OP_CONDITION, 8'd0, 6'd0, 6'd0, 32'd0, 16'd0));
        add_row(row_txn(OP_SELECT, 8'd0, 6'd0, 6'd0, 32'd0, 16'hC000));

        // Random phases: small case counts for the conditioning modes, and
        // large case counts only in raw mode with few transactions.
        add_phase('{3, 0, MODE_REL, 32'h0000_8000, 32'hFFFF_FFFF, 20});
        add_phase('{1, 0, MODE_ABS, 32'h0002_0000, 32'hFFFF_FFFF, 15});
        add_phase('{5, 3, MODE_STD, 32'h0000_0000, 32'h0003_0000, 20});
        add_phase('{4, 1, MODE_STD, 32'h0001_0000, 32'hFFFF_FFFF, 20});
        add_phase('{2, 2, MODE_REL, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 15});
        add_phase('{60, 0, MODE_RAW, 32'h0000_0000, 32'hFFFF_FFFF, 5});
        add_phase('{64, 0, MODE_RAW, 32'h0000_0000, 32'h0000_0000, 5});

        // Hold reset low, then release it.
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed[k]) begin
            if (directed[k].is_cfg) begin
                quiesce();
                write_reg(directed[k].reg_idx, directed[k].reg_val);
            end else begin
                send(directed[k].txn, directed[k].typed, directed[k].want);
            end
        end

        foreach (phases[p]) begin
            quiesce();
            write_reg(REG_NUM_CASES, phases[p].ncases);
            write_reg(REG_META, phases[p].meta);
            write_reg(REG_MODE, phases[p].mode);
            write_reg(REG_EPSILON, phases[p].eps);
            write_reg(REG_MAX_ERR, phases[p].maxe);
            for (int k = 0; k < phases[p].items; k++)
                send(random_txn(), 1'b0, '0);
        end

        // Drain and let any trailing conditioning pass finish.
        quiesce();
        repeat (50) @(posedge i_clk);
        if (fails == 0) begin
            $display("epsilon_lexicase_parent_selection verification clean");
        end else begin
            $display("epsilon_lexicase_parent_selection verification failed");
        end
        $finish;
    end
endmodule
